// ===== src/lmi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmi_pkg: shared types and constants of the linear motion interpolator
// Holds the channel payload structs, register indexes and controller states.
// ----------------------------------------------------------------------------
package lmi_pkg;

   localparam int PosW  = 24;
   localparam int CfgW  = 24;
   localparam int RegW  = 16;
   localparam int CsrIdxW = 3;

   localparam logic [1:0] ModeTick     = 2'd0;
   localparam logic [1:0] ModeTarget   = 2'd1;
   localparam logic [1:0] ModeHome     = 2'd2;
   localparam logic [1:0] ModeReserved = 2'd3;

   localparam logic [CsrIdxW-1:0] RegStepLength   = 3'd0;
   localparam logic [CsrIdxW-1:0] RegReachRadius  = 3'd1;
   localparam logic [CsrIdxW-1:0] RegStepInterval = 3'd2;
   localparam logic [CsrIdxW-1:0] RegOffsetX      = 3'd3;
   localparam logic [CsrIdxW-1:0] RegOffsetY      = 3'd4;
   localparam logic [CsrIdxW-1:0] RegOffsetZ      = 3'd5;
   localparam logic [CsrIdxW-1:0] RegHomeZ        = 3'd6;

   typedef struct packed {
      logic [1:0]             mode;
      logic signed [PosW-1:0] target_x;
      logic signed [PosW-1:0] target_y;
      logic signed [PosW-1:0] target_z;
   } req_type;

   typedef struct packed {
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] pos_z;
      logic                   moving;
      logic                   arrived;
      logic                   stepped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_SQUARE, ST_SQRT, ST_CHECK,
      ST_MULT, ST_DIV, ST_APPLY, ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, do mode 1/2 work, tick count
      logic diff;      // form saturated differences
      logic square;    // square one axis per cycle
      logic sqrt_start;
      logic sqrt_step;
      logic check;     // compare distance to reach
      logic mult;      // multiply one axis by step length
      logic div_start;
      logic div_step;
      logic apply;     // add one axis step
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic step_due;
      logic axis_last;
      logic sqrt_done;
      logic in_reach;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== src/lmi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmi_ctrl: sequencing controller
// Walks one transaction through difference, square root, divide and update.
// ----------------------------------------------------------------------------
module lmi_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  wire lmi_pkg::sts_type sts,
   output lmi_pkg::cmd_type    cmd
);
   import lmi_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   // output register is free once taken; a waiting result blocks the next load only
   wire out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.step_due) begin
               cmd.diff = 1'b1;
               state_in = ST_SQUARE;
            end else if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            if (sts.axis_last) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in = sts.in_reach ? ST_OUT : ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               cmd.apply = 1'b1;
               state_in = sts.axis_last ? ST_OUT : ST_MULT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/lmi_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmi_datapath: position state, registers and arithmetic units
// Holds the position, goal and register file; runs a bit-pair square root
// and a restoring divider, one axis at a time.
// ----------------------------------------------------------------------------
module lmi_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_we,
   input  wire [lmi_pkg::CsrIdxW-1:0] csr_index,
   input  wire [lmi_pkg::CfgW-1:0]    csr_wdata,
   input  wire [1:0]           in_mode,
   input  wire [lmi_pkg::PosW-1:0] in_tx,
   input  wire [lmi_pkg::PosW-1:0] in_ty,
   input  wire [lmi_pkg::PosW-1:0] in_tz,
   input  wire lmi_pkg::cmd_type cmd,
   output lmi_pkg::sts_type    sts,
   output logic [lmi_pkg::PosW-1:0] o_x,
   output logic [lmi_pkg::PosW-1:0] o_y,
   output logic [lmi_pkg::PosW-1:0] o_z,
   output logic                o_moving,
   output logic                o_arrived,
   output logic                o_stepped
);
   import lmi_pkg::*;

   localparam int PW   = PosW;
   localparam int SQW  = 2*PW + 2;           // sum of three squares
   localparam int RTW  = PW + 1;             // root width
   localparam int NUMW = PW + RegW;          // |d| * step_length
   localparam int SQIT = SQW / 2;
   localparam int CW   = $clog2(NUMW + 1);
   localparam int SCW  = $clog2(SQIT + 1);
   localparam logic signed [PW:0] PMax = {2'b00, {(PW-1){1'b1}}};
   localparam logic signed [PW:0] PMin = {2'b11, {(PW-1){1'b0}}};
   localparam logic signed [PW-1:0] HomeZReset = PW'(38400);
   localparam logic signed [PW-1:0] OffZReset  = -PW'(2048);

   logic [RegW-1:0] step_len_ff, reach_ff, interval_ff;
   logic signed [PW-1:0] offx_ff, offy_ff, offz_ff, homez_ff;
   logic signed [PW-1:0] cur_ff [3];
   logic signed [PW-1:0] goal_ff [3];
   logic signed [PW-1:0] d_ff [3];
   logic move_ff, home_done_ff, arrived_ff, stepped_ff, due_ff;
   logic [RegW-1:0] tick_ff;
   logic [1:0] axis_ff;
   logic [SQW-1:0] sum_ff, rem_ff;
   logic [RTW-1:0] root_ff;
   logic [SCW-1:0] sqc_ff;
   logic [NUMW-1:0] num_ff;
   logic [NUMW-1:0] quo_ff;
   logic [NUMW:0]   drem_ff;
   logic [CW-1:0]   dc_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         step_len_ff <= RegW'(102);
         reach_ff    <= RegW'(256);
         interval_ff <= RegW'(5);
         offx_ff     <= '0;
         offy_ff     <= '0;
         offz_ff     <= OffZReset;
         homez_ff    <= HomeZReset;
      end else if (csr_we) begin
         unique case (csr_index)
            RegStepLength:   step_len_ff <= csr_wdata[RegW-1:0];
            RegReachRadius:  reach_ff    <= csr_wdata[RegW-1:0];
            RegStepInterval: interval_ff <= csr_wdata[RegW-1:0];
            RegOffsetX:      offx_ff     <= csr_wdata;
            RegOffsetY:      offy_ff     <= csr_wdata;
            RegOffsetZ:      offz_ff     <= csr_wdata;
            RegHomeZ:        homez_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic signed [PW-1:0] sat_f(input logic signed [PW+1:0] v);
      if (v > (PW+2)'(PMax)) return PMax[PW-1:0];
      if (v < (PW+2)'(PMin)) return PMin[PW-1:0];
      return v[PW-1:0];
   endfunction

   // selected axis
   logic signed [PW-1:0] d_sel, cur_sel;
   always_comb begin
      d_sel   = d_ff[axis_ff];
      cur_sel = cur_ff[axis_ff];
   end
   wire [PW-1:0] d_mag = d_sel[PW-1] ? PW'(-d_sel) : PW'(d_sel);

   // square root: one bit pair per cycle
   wire [SQW-1:0] sq_trial = {rem_ff[SQW-3:0], sum_ff[SQW-1 -: 2]};
   wire [SQW-1:0] sq_cmp   = SQW'({root_ff, 2'b01});
   // divide: one quotient bit per cycle
   wire [NUMW:0] dv_shift = {drem_ff[NUMW-1:0], num_ff[NUMW-1]};
   wire [NUMW:0] dv_den   = (NUMW+1)'(root_ff);
   wire signed [PW+1:0] new_pos = (PW+2)'(cur_sel) +
      (d_sel[PW-1] ? -(PW+2)'(quo_ff) : (PW+2)'(quo_ff));

   wire [RegW-1:0] tick_inc = (tick_ff == {RegW{1'b1}}) ? tick_ff : tick_ff + 1'b1;

   assign sts.step_due  = due_ff;
   assign sts.axis_last = (axis_ff == 2'd2);
   assign sts.sqrt_done = (sqc_ff == '0);
   assign sts.in_reach  = (root_ff <= RTW'(reach_ff));
   assign sts.div_done  = (dc_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff[0] <= '0; cur_ff[1] <= '0; cur_ff[2] <= HomeZReset;
         goal_ff[0] <= '0; goal_ff[1] <= '0; goal_ff[2] <= '0;
         move_ff <= 1'b0; home_done_ff <= 1'b0; tick_ff <= '0;
         due_ff <= 1'b0; arrived_ff <= 1'b0; stepped_ff <= 1'b0;
         axis_ff <= '0; sqc_ff <= '0; dc_ff <= '0;
      end else begin
         if (cmd.load) begin
            arrived_ff <= 1'b0; stepped_ff <= 1'b0; due_ff <= 1'b0;
            case (in_mode)
               ModeTarget: begin
                  goal_ff[0] <= in_tx; goal_ff[1] <= in_ty; goal_ff[2] <= in_tz;
                  move_ff <= 1'b1; tick_ff <= '0;
               end
               ModeHome: if (!home_done_ff) begin
                  home_done_ff <= 1'b1;
                  cur_ff[0] <= '0; cur_ff[1] <= '0; cur_ff[2] <= homez_ff;
               end
               ModeTick: if (move_ff) begin
                  tick_ff <= tick_inc;
                  due_ff  <= (tick_inc >= interval_ff);
               end
               default: ;
            endcase
         end
         if (cmd.diff) begin
            due_ff <= 1'b0; tick_ff <= '0;
            d_ff[0] <= sat_f((PW+2)'(goal_ff[0]) - (PW+2)'(cur_ff[0]) + (PW+2)'(offx_ff));
            d_ff[1] <= sat_f((PW+2)'(goal_ff[1]) - (PW+2)'(cur_ff[1]) + (PW+2)'(offy_ff));
            d_ff[2] <= sat_f((PW+2)'(goal_ff[2]) - (PW+2)'(cur_ff[2]) + (PW+2)'(offz_ff));
            axis_ff <= '0;
            sum_ff  <= '0;
         end
         if (cmd.square) begin
            sum_ff  <= sum_ff + SQW'(d_mag * d_mag);
            axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
         end
         if (cmd.sqrt_start) begin
            rem_ff  <= '0; root_ff <= '0; sqc_ff <= SCW'(SQIT);
         end
         if (cmd.sqrt_step && sqc_ff != '0) begin
            sum_ff <= sum_ff << 2;
            sqc_ff <= sqc_ff - 1'b1;
            if (sq_trial >= sq_cmp) begin
               rem_ff  <= sq_trial - sq_cmp;
               root_ff <= {root_ff[RTW-2:0], 1'b1};
            end else begin
               rem_ff  <= sq_trial;
               root_ff <= {root_ff[RTW-2:0], 1'b0};
            end
         end
         if (cmd.check) begin
            axis_ff <= '0;
            if (sts.in_reach) begin
               move_ff <= 1'b0; arrived_ff <= 1'b1;
            end else stepped_ff <= 1'b1;
         end
         if (cmd.mult) num_ff <= NUMW'(d_mag * step_len_ff);
         if (cmd.div_start) begin
            drem_ff <= '0; quo_ff <= '0; dc_ff <= CW'(NUMW);
         end
         if (cmd.div_step && dc_ff != '0) begin
            num_ff <= num_ff << 1;
            dc_ff  <= dc_ff - 1'b1;
            if (dv_shift >= dv_den) begin
               drem_ff <= dv_shift - dv_den;
               quo_ff  <= {quo_ff[NUMW-2:0], 1'b1};
            end else begin
               drem_ff <= dv_shift;
               quo_ff  <= {quo_ff[NUMW-2:0], 1'b0};
            end
         end
         if (cmd.apply) begin
            cur_ff[axis_ff] <= sat_f(new_pos);
            axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_x <= cur_ff[0]; o_y <= cur_ff[1]; o_z <= cur_ff[2];
         o_moving <= move_ff; o_arrived <= arrived_ff; o_stepped <= stepped_ff;
      end
   end

endmodule
`default_nettype wire

// ===== src/linear_motion_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_motion_interpolator: three-axis straight-line step generator
// Controller plus datapath around square root and divide units.
// ----------------------------------------------------------------------------
// One transaction at a time. Set-target, home, reserved-mode and non-stepping
// ticks go from acceptance to the output state, which loads the result
// register once that register is free. A tick that steps first forms the
// differences, squares each axis into a sum and runs a bit-pair square root
// over it; if the target is then in reach, it goes to the output state. A tick
// that moves adds, for each axis, a multiply, a bit-serial divide and an update.
// The result sits in an output register; the next transaction is taken once
// it is loaded, and a stalled result holds only the following one.
module linear_motion_interpolator (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire lmi_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output lmi_pkg::rsp_type    rsp_data,
   input  wire                 csr_we,
   input  wire [lmi_pkg::CsrIdxW-1:0] csr_index,
   input  wire [lmi_pkg::CfgW-1:0]    csr_wdata
);
   import lmi_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lmi_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   lmi_datapath u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .in_mode(req_data.mode),
      .in_tx(req_data.target_x), .in_ty(req_data.target_y),
      .in_tz(req_data.target_z), .cmd(cmd), .sts(sts),
      .o_x(rsp_data.pos_x), .o_y(rsp_data.pos_y), .o_z(rsp_data.pos_z),
      .o_moving(rsp_data.moving), .o_arrived(rsp_data.arrived),
      .o_stepped(rsp_data.stepped)
   );

endmodule
`default_nettype wire
